FILE: sv/crbe_pkg.sv
// crbe_pkg: shared types, widths and action codes of the counter bank rate estimator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package crbe_pkg;

  localparam int BANK_DEPTH     = 32;
  localparam int IDX_W          = 5;
  localparam int VALUE_BITS     = 48;
  localparam int RATE_FRAC_BITS = 16;
  localparam int RATE_W         = 64;
  localparam int TIME_W         = 32;
  localparam int INTERVAL_W     = 8;
  localparam int ACTION_W       = 3;
  localparam int DVD_W          = VALUE_BITS + RATE_FRAC_BITS;
  localparam int DIV_CNT_W      = $clog2(DVD_W);

  localparam logic [IDX_W:0]        BANK_DEPTH_L   = (IDX_W + 1)'(BANK_DEPTH);
  localparam logic [IDX_W-1:0]      LAST_COUNTER   = IDX_W'(BANK_DEPTH - 1);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(5);
  localparam logic [RATE_W-1:0]     RATE_MAX       = {1'b0, {(RATE_W - 1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VALUE_MAX      = {VALUE_BITS{1'b1}};

  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SET   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ADD   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    counter_index;
    logic [47:0]         operand;
    logic [TIME_W-1:0]   time_seconds;
  } in_item_t;

  typedef struct packed {
    logic [47:0]        counter_value;
    logic signed [63:0] counter_rate;
    logic               rates_updated;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: sv/crbe_div.sv
// crbe_div: bit-serial restoring divider, one quotient bit per cycle
// depends on crbe_pkg for widths and the status struct
`timescale 1ns / 1ps
`default_nettype none

module crbe_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [crbe_pkg::DVD_W-1:0]      dividend,
  input  wire logic [crbe_pkg::TIME_W-1:0]     divisor,
  output logic      [crbe_pkg::DVD_W-1:0]      quotient,
  output crbe_pkg::div_stat_t                  stat
);

  logic [crbe_pkg::DVD_W-1:0]     dvd_r;
  logic [crbe_pkg::TIME_W-1:0]    rem_r;
  logic [crbe_pkg::TIME_W-1:0]    dsr_r;
  logic [crbe_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [crbe_pkg::TIME_W:0]   rem_sh;
  logic                        ge;
  logic [crbe_pkg::TIME_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[crbe_pkg::DVD_W-1]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_nxt = ge ? crbe_pkg::TIME_W'(rem_sh - {1'b0, dsr_r})
                 : rem_sh[crbe_pkg::TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        dvd_r <= {dvd_r[crbe_pkg::DVD_W-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == crbe_pkg::DIV_CNT_W'(crbe_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end
    end
  end

  assign quotient  = dvd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

FILE: sv/crbe_rate_upd.sv
// crbe_rate_upd: signed rate from a quotient with saturation, and quarter-weight blend
// depends on crbe_pkg for widths and limits
`timescale 1ns / 1ps
`default_nettype none

module crbe_rate_upd (
  input  wire logic [crbe_pkg::DVD_W-1:0]  quotient,
  input  wire logic                        neg,
  input  wire logic [crbe_pkg::RATE_W-1:0] prior_rate,
  output logic      [crbe_pkg::RATE_W-1:0] blended_rate
);

  logic [crbe_pkg::RATE_W-1:0] q_ext;
  logic [crbe_pkg::RATE_W-1:0] mag;
  logic [crbe_pkg::RATE_W-1:0] fresh;
  logic [crbe_pkg::RATE_W+1:0] old_ext;
  logic [crbe_pkg::RATE_W+1:0] fresh_ext;
  logic [crbe_pkg::RATE_W+1:0] sum;

  always_comb begin
    q_ext        = crbe_pkg::RATE_W'(quotient);
    mag          = q_ext[crbe_pkg::RATE_W-1] ? crbe_pkg::RATE_MAX : q_ext;
    fresh        = neg ? (~mag + 1'b1) : mag;
    old_ext      = {{2{prior_rate[crbe_pkg::RATE_W-1]}}, prior_rate};
    fresh_ext    = {{2{fresh[crbe_pkg::RATE_W-1]}}, fresh};
    // 3*old + new, floor divided by four
    sum          = old_ext + {old_ext[crbe_pkg::RATE_W:0], 1'b0} + fresh_ext;
    blended_rate = (prior_rate == '0) ? fresh : sum[crbe_pkg::RATE_W+1:2];
  end

endmodule

`default_nettype wire

FILE: sv/counter_bank_rate_estimator.sv
// counter_bank_rate_estimator: top level with sequencer and counter, last value and rate stores
// depends on crbe_pkg, crbe_div and crbe_rate_upd
`timescale 1ns / 1ps
`default_nettype none

// A read, clear, set or add item is registered in the accepting cycle; the execute state then
// updates the addressed counter and loads the output register, but waits until the output
// register is free. A tick that falls due walks all 32 counters through one shared bit-serial
// divider that yields one quotient bit per cycle; each counter goes through load, the divide
// steps, a wait to see the divider finish, and the write of its rate, and the walk result is
// loaded into the output register once the last counter is written and the register is free.
// A tick that is not due, or the first tick, completes in the execute state like other items.
// in_ready is high only while no item is in work; the output register holds a finished result
// until out_ready takes it, and the next item can be accepted meanwhile, but it waits for the
// output register to free before it completes.

module counter_bank_rate_estimator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire crbe_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output crbe_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [crbe_pkg::INTERVAL_W-1:0]     cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]                         state_r;
  logic [2:0]                         state_nxt;
  crbe_pkg::in_item_t                 item_r;
  logic                               out_valid_r;
  crbe_pkg::out_item_t                out_data_r;
  logic [crbe_pkg::INTERVAL_W-1:0]    interval_r;
  logic [crbe_pkg::TIME_W-1:0]        last_time_r;
  logic                               time_seen_r;
  logic [crbe_pkg::IDX_W-1:0]         walk_r;
  logic [crbe_pkg::TIME_W-1:0]        age_r;
  logic                               neg_r;

  logic [crbe_pkg::VALUE_BITS-1:0] val_r  [crbe_pkg::BANK_DEPTH];
  logic [crbe_pkg::VALUE_BITS-1:0] prev_r [crbe_pkg::BANK_DEPTH];
  logic [crbe_pkg::RATE_W-1:0]     rate_r [crbe_pkg::BANK_DEPTH];

  logic                               out_free;
  logic                               out_load;
  logic                               idx_ok;
  logic [crbe_pkg::VALUE_BITS-1:0]    cur_val;
  logic [crbe_pkg::VALUE_BITS:0]      add_sum;
  logic [crbe_pkg::VALUE_BITS-1:0]    op_val;
  logic [crbe_pkg::VALUE_BITS-1:0]    new_val;
  logic [crbe_pkg::TIME_W-1:0]        age;
  logic                               tick_due;
  logic                               is_tick;
  logic [crbe_pkg::VALUE_BITS-1:0]    walk_val;
  logic [crbe_pkg::VALUE_BITS-1:0]    walk_prev;
  logic                               walk_neg;
  logic [crbe_pkg::VALUE_BITS-1:0]    walk_mag;
  logic                               div_start;
  logic [crbe_pkg::DVD_W-1:0]         div_quot;
  crbe_pkg::div_stat_t                div_stat;
  logic [crbe_pkg::RATE_W-1:0]        upd_rate;
  crbe_pkg::out_item_t                exec_resp;
  crbe_pkg::out_item_t                walk_resp;

  crbe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({walk_mag, {crbe_pkg::RATE_FRAC_BITS{1'b0}}}),
    .divisor  (age_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  crbe_rate_upd u_rate_upd (
    .quotient     (div_quot),
    .neg          (neg_r),
    .prior_rate   (rate_r[walk_r]),
    .blended_rate (upd_rate)
  );

  always_comb begin
    out_free = !out_valid_r || out_ready;
    is_tick  = item_r.action == crbe_pkg::ACT_TICK;
    idx_ok   = {1'b0, item_r.counter_index} < crbe_pkg::BANK_DEPTH_L;
    cur_val  = val_r[item_r.counter_index];
    op_val   = crbe_pkg::VALUE_BITS'(item_r.operand);
    add_sum  = {1'b0, cur_val} + {1'b0, op_val};
    case (item_r.action)
      crbe_pkg::ACT_CLEAR: new_val = '0;
      crbe_pkg::ACT_SET:   new_val = op_val;
      crbe_pkg::ACT_ADD:   new_val = add_sum[crbe_pkg::VALUE_BITS] ? crbe_pkg::VALUE_MAX
                                                                   : add_sum[crbe_pkg::VALUE_BITS-1:0];
      default:             new_val = cur_val;
    endcase
    age      = item_r.time_seconds - last_time_r;
    tick_due = time_seen_r && (age != '0) &&
               (age >= crbe_pkg::TIME_W'(interval_r));
    out_load = out_free && (((state_r == S_EXEC) && !(is_tick && tick_due)) ||
                            (state_r == S_RESP));

    exec_resp.rates_updated = 1'b0;
    if (!idx_ok) begin
      exec_resp.counter_value = '0;
      exec_resp.counter_rate  = '0;
    end else if (is_tick) begin
      exec_resp.counter_value = 48'(cur_val);
      exec_resp.counter_rate  = rate_r[item_r.counter_index];
    end else begin
      exec_resp.counter_value = 48'(new_val);
      exec_resp.counter_rate  = (item_r.action == crbe_pkg::ACT_CLEAR) ? '0
                                : rate_r[item_r.counter_index];
    end

    walk_resp.rates_updated = 1'b1;
    walk_resp.counter_value = idx_ok ? 48'(cur_val) : '0;
    walk_resp.counter_rate  = idx_ok ? rate_r[item_r.counter_index] : '0;

    walk_val  = val_r[walk_r];
    walk_prev = prev_r[walk_r];
    walk_neg  = walk_val < walk_prev;
    walk_mag  = walk_neg ? (walk_prev - walk_val) : (walk_val - walk_prev);
    div_start = state_r == S_LOAD;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: if (out_free) state_nxt = (is_tick && tick_due) ? S_LOAD : S_IDLE;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_UPD;
      S_UPD:  state_nxt = (walk_r == crbe_pkg::LAST_COUNTER) ? S_RESP : S_LOAD;
      S_RESP: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      interval_r  <= crbe_pkg::INTERVAL_RESET;
      last_time_r <= '0;
      time_seen_r <= 1'b0;
      walk_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) interval_r <= cfg_wdata;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) item_r <= in_data;
        end
        S_EXEC: begin
          if (out_free) begin
            if (is_tick && !time_seen_r) begin
              time_seen_r <= 1'b1;
              last_time_r <= item_r.time_seconds;
            end
            if (is_tick && tick_due) begin
              last_time_r <= item_r.time_seconds;
              age_r       <= age;
              walk_r      <= '0;
            end else begin
              out_data_r  <= exec_resp;
            end
          end
        end
        S_LOAD: neg_r <= walk_neg;
        S_UPD:  walk_r <= walk_r + 1'b1;
        S_RESP: begin
          if (out_free) begin
            out_data_r  <= walk_resp;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < crbe_pkg::BANK_DEPTH; i++) begin
        val_r[i]  <= '0;
        prev_r[i] <= '0;
        rate_r[i] <= '0;
      end
    end else begin
      if (state_r == S_EXEC && out_free && !is_tick && idx_ok) begin
        val_r[item_r.counter_index] <= new_val;
        if (item_r.action == crbe_pkg::ACT_CLEAR) begin
          prev_r[item_r.counter_index] <= '0;
          rate_r[item_r.counter_index] <= '0;
        end
      end
      if (state_r == S_UPD) begin
        rate_r[walk_r] <= upd_rate;
        prev_r[walk_r] <= walk_val;
      end
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && !div_stat.busy |-> div_stat.done)
    else $error("sequencer waits on an idle divider");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EXEC)
    else $error("accepted item not executed");

  a_upd_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && out_free |=> out_valid_r && out_data_r.rates_updated)
    else $error("walk result without rates_updated");

endmodule

`default_nettype wire

FILE: sim/counter_bank_rate_estimator_tb.sv
// counter_bank_rate_estimator_tb: self-checking bench for the counter bank rate estimator
// drives directed and random items under random stalls, mirrors the bank to check results
// depends on crbe_pkg and counter_bank_rate_estimator
`timescale 1ns / 1ps

module counter_bank_rate_estimator_tb;

  localparam logic [crbe_pkg::ACTION_W-1:0] ACT_RSVD_FIRST = 3'd5;
  localparam logic [crbe_pkg::ACTION_W-1:0] ACT_RSVD_LAST  = 3'd7;
  localparam int PHASE_ITEMS    = 205;
  localparam int HOLD_AT        = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 20000;

  class counter_bank_mirror;
    logic [crbe_pkg::VALUE_BITS-1:0] value_q   [crbe_pkg::BANK_DEPTH];
    logic [crbe_pkg::VALUE_BITS-1:0] sampled_q [crbe_pkg::BANK_DEPTH];
    logic [crbe_pkg::RATE_W-1:0]     rate_q    [crbe_pkg::BANK_DEPTH];
    logic [crbe_pkg::TIME_W-1:0]     last_tick;
    bit                              time_known;
    logic [crbe_pkg::INTERVAL_W-1:0] interval;
    crbe_pkg::out_item_t             pending_readings[$];
    int                              errors;

    function new();
      for (int i = 0; i < crbe_pkg::BANK_DEPTH; i++) begin
        value_q[i]   = '0;
        sampled_q[i] = '0;
        rate_q[i]    = '0;
      end
      last_tick  = '0;
      time_known = 0;
      interval   = crbe_pkg::INTERVAL_RESET;
      errors     = 0;
    endfunction

    function void set_interval(logic [crbe_pkg::INTERVAL_W-1:0] v);
      interval = v;
    endfunction

    function logic [crbe_pkg::RATE_W-1:0] change_rate(
        logic [crbe_pkg::VALUE_BITS-1:0] now_v,
        logic [crbe_pkg::VALUE_BITS-1:0] then_v,
        logic [crbe_pkg::TIME_W-1:0] age);
      logic [crbe_pkg::RATE_W-1:0] mag;
      logic [crbe_pkg::RATE_W-1:0] quo;
      logic                        neg;
      neg = now_v < then_v;
      mag = neg ? crbe_pkg::RATE_W'(then_v - now_v) : crbe_pkg::RATE_W'(now_v - then_v);
      quo = (mag << crbe_pkg::RATE_FRAC_BITS) / crbe_pkg::RATE_W'(age);
      if (quo > crbe_pkg::RATE_MAX) quo = crbe_pkg::RATE_MAX;
      return neg ? -quo : quo;
    endfunction

    // floor((3*old + new) / 4) on two's complement rates
    function logic [crbe_pkg::RATE_W-1:0] blend_rate(logic [crbe_pkg::RATE_W-1:0] old_r,
                                                     logic [crbe_pkg::RATE_W-1:0] new_r);
      logic signed [crbe_pkg::RATE_W+1:0] acc;
      acc = {{2{old_r[crbe_pkg::RATE_W-1]}}, old_r} * 66'd3 +
            {{2{new_r[crbe_pkg::RATE_W-1]}}, new_r};
      acc = acc >>> 2;
      return acc[crbe_pkg::RATE_W-1:0];
    endfunction

    function crbe_pkg::out_item_t apply_action(crbe_pkg::in_item_t it);
      crbe_pkg::out_item_t         r;
      logic [crbe_pkg::TIME_W-1:0] age;
      logic [crbe_pkg::RATE_W-1:0] fresh;
      logic [crbe_pkg::IDX_W-1:0]  k;
      k = it.counter_index;
      r.rates_updated = 1'b0;
      case (it.action)
        crbe_pkg::ACT_TICK: begin
          if (!time_known) begin
            time_known = 1;
            last_tick  = it.time_seconds;
          end else begin
            age = it.time_seconds - last_tick;
            if (age != 0 && age >= crbe_pkg::TIME_W'(interval)) begin
              last_tick = it.time_seconds;
              for (int i = 0; i < crbe_pkg::BANK_DEPTH; i++) begin
                fresh        = change_rate(value_q[i], sampled_q[i], age);
                rate_q[i]    = (rate_q[i] == '0) ? fresh : blend_rate(rate_q[i], fresh);
                sampled_q[i] = value_q[i];
              end
              r.rates_updated = 1'b1;
            end
          end
        end
        crbe_pkg::ACT_CLEAR: begin
          value_q[k]   = '0;
          sampled_q[k] = '0;
          rate_q[k]    = '0;
        end
        crbe_pkg::ACT_SET: value_q[k] = it.operand;
        crbe_pkg::ACT_ADD: begin
          value_q[k] = (it.operand > crbe_pkg::VALUE_MAX - value_q[k])
                       ? crbe_pkg::VALUE_MAX : value_q[k] + it.operand;
        end
        default: ;
      endcase
      r.counter_value = value_q[k];
      r.counter_rate  = rate_q[k];
      return r;
    endfunction

    function void take_item(crbe_pkg::in_item_t it);
      pending_readings.push_back(apply_action(it));
    endfunction

    function void match_result(crbe_pkg::out_item_t got);
      crbe_pkg::out_item_t want;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result value=%h rate=%h updated=%b", $time,
                 got.counter_value, got.counter_rate, got.rates_updated);
        errors++;
        return;
      end
      want = pending_readings.pop_front();
      if (got.counter_value !== want.counter_value) begin
        $display("%0t: counter_value expected %h actual %h", $time,
                 want.counter_value, got.counter_value);
        errors++;
      end
      if (got.counter_rate !== want.counter_rate) begin
        $display("%0t: counter_rate expected %h actual %h", $time,
                 want.counter_rate, got.counter_rate);
        errors++;
      end
      if (got.rates_updated !== want.rates_updated) begin
        $display("%0t: rates_updated expected %b actual %b", $time,
                 want.rates_updated, got.rates_updated);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  crbe_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  crbe_pkg::out_item_t             out_data;
  logic                            cfg_we;
  logic [crbe_pkg::INTERVAL_W-1:0] cfg_wdata;

  counter_bank_mirror              board;
  logic [crbe_pkg::TIME_W-1:0]     tick_clock;
  logic [crbe_pkg::INTERVAL_W-1:0] cur_interval;
  bit                              tx_burst;
  int                              stall_cycles;

  counter_bank_rate_estimator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[counter_bank_rate_estimator] ERROR");
      $finish;
    end
  end

  task automatic send_item(input crbe_pkg::in_item_t it);
    int gap;
    if ($urandom_range(39, 0) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(9, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    board.take_item(it);
  endtask

  task automatic send_fields(input logic [crbe_pkg::ACTION_W-1:0] act,
                             input logic [crbe_pkg::IDX_W-1:0] idx,
                             input logic [47:0] opnd,
                             input logic [crbe_pkg::TIME_W-1:0] secs);
    crbe_pkg::in_item_t it;
    it.action        = act;
    it.counter_index = idx;
    it.operand       = opnd;
    it.time_seconds  = secs;
    send_item(it);
  endtask

  task automatic write_interval(input logic [crbe_pkg::INTERVAL_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_readings.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    board.set_interval(v);
    cur_interval = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic crbe_pkg::in_item_t random_item();
    crbe_pkg::in_item_t          it;
    int                          pick;
    int                          sub;
    int                          span;
    logic [crbe_pkg::TIME_W-1:0] step;
    it.action        = crbe_pkg::ACT_READ;
    it.counter_index = crbe_pkg::IDX_W'($urandom_range(crbe_pkg::LAST_COUNTER, 0));
    it.operand       = 48'({$urandom(), $urandom()});
    it.time_seconds  = $urandom();
    pick = $urandom_range(99, 0);
    sub  = $urandom_range(19, 0);
    if (pick < 6) begin
      it.action = crbe_pkg::ACT_TICK;
      span = (cur_interval == 0) ? 1 : int'(cur_interval);
      if (sub < 13)       step = crbe_pkg::TIME_W'(span + $urandom_range(span, 0));
      else if (sub < 16)  step = crbe_pkg::TIME_W'($urandom_range(span - 1, 0));
      else if (sub == 16) step = '0;
      else if (sub == 17) step = crbe_pkg::TIME_W'(1);
      else                step = $urandom();
      tick_clock      = tick_clock + step;
      it.time_seconds = tick_clock;
    end else if (pick < 46) begin
      it.action = crbe_pkg::ACT_ADD;
      if (sub < 10)      it.operand = 48'($urandom_range(1000, 1));
      else if (sub < 13) it.operand = 48'(1);
      else if (sub < 16) it.operand = 48'({$urandom(), 16'h0});
      else if (sub < 18) it.operand = crbe_pkg::VALUE_MAX;
    end else if (pick < 61) begin
      it.action = crbe_pkg::ACT_SET;
      if (sub < 4)       it.operand = 48'($urandom_range(5000, 0));
      else if (sub < 6)  it.operand = '0;
      else if (sub < 8)  it.operand = crbe_pkg::VALUE_MAX;
    end else if (pick < 81) begin
      it.action = crbe_pkg::ACT_READ;
    end else if (pick < 88) begin
      it.action = crbe_pkg::ACT_CLEAR;
    end else begin
      it.action = crbe_pkg::ACTION_W'($urandom_range(ACT_RSVD_LAST, ACT_RSVD_FIRST));
    end
    return it;
  endfunction

  initial begin
    int got_count;
    int gap;
    bit rx_burst;
    got_count = 0;
    rx_burst  = 0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(39, 0) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(9, 0);
      if (got_count == HOLD_AT) gap = HOLD_CYCLES;
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.match_result(out_data);
      got_count++;
    end
  end

  initial begin
    logic [crbe_pkg::INTERVAL_W-1:0] settings [4];
    board        = new();
    tick_clock   = '0;
    cur_interval = crbe_pkg::INTERVAL_RESET;
    tx_burst     = 0;
    stall_cycles = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    settings[0] = crbe_pkg::INTERVAL_W'(1);
    settings[1] = crbe_pkg::INTERVAL_W'(255);
    settings[2] = crbe_pkg::INTERVAL_W'(0);
    settings[3] = crbe_pkg::INTERVAL_W'($urandom_range(254, 2));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes of value and saturation, undefined actions, tick timing corners
    send_fields(crbe_pkg::ACT_READ,  5'd0, '0, '0);
    send_fields(crbe_pkg::ACT_READ,  crbe_pkg::LAST_COUNTER, '1, '1);
    send_fields(crbe_pkg::ACT_SET,   5'd0, crbe_pkg::VALUE_MAX, '0);
    send_fields(crbe_pkg::ACT_ADD,   5'd0, 48'(1), '0);
    send_fields(crbe_pkg::ACT_ADD,   5'd0, crbe_pkg::VALUE_MAX, '0);
    send_fields(crbe_pkg::ACT_ADD,   5'd1, crbe_pkg::VALUE_MAX, '0);
    send_fields(crbe_pkg::ACT_SET,   5'd2, 48'(123456), '0);
    send_fields(crbe_pkg::ACT_ADD,   5'd2, 48'(1), '0);
    send_fields(crbe_pkg::ACT_CLEAR, 5'd2, '0, '0);
    for (int a = ACT_RSVD_FIRST; a <= ACT_RSVD_LAST; a++) begin
      send_fields(crbe_pkg::ACTION_W'(a), 5'd3, 48'({$urandom(), $urandom()}), $urandom());
    end
    send_fields(crbe_pkg::ACT_TICK,  5'd0, '0, 32'd100);
    send_fields(crbe_pkg::ACT_TICK,  5'd0, '0, 32'd100);
    send_fields(crbe_pkg::ACT_TICK,  5'd1, '0, 32'd103);
    send_fields(crbe_pkg::ACT_SET,   5'd4, 48'(1000), '0);
    send_fields(crbe_pkg::ACT_TICK,  5'd4, '0, 32'd105);
    send_fields(crbe_pkg::ACT_SET,   5'd0, '0, '0);
    send_fields(crbe_pkg::ACT_SET,   5'd4, 48'(40), '0);
    send_fields(crbe_pkg::ACT_TICK,  5'd0, '0, 32'd110);
    send_fields(crbe_pkg::ACT_TICK,  5'd4, '0, 32'hFFFF_FFF0);
    send_fields(crbe_pkg::ACT_TICK,  5'd1, '0, 32'd5);
    send_fields(crbe_pkg::ACT_CLEAR, 5'd0, '0, '0);
    send_fields(crbe_pkg::ACT_READ,  5'd0, '0, '0);
    send_fields(crbe_pkg::ACT_READ,  5'd4, '0, '0);
    tick_clock = 32'd5;

    repeat (PHASE_ITEMS) send_item(random_item());
    foreach (settings[p]) begin
      write_interval(settings[p]);
      repeat (PHASE_ITEMS) send_item(random_item());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.errors += board.pending_readings.size();
    if (board.errors == 0) begin
      $display("[counter_bank_rate_estimator] OK");
    end else begin
      $display("[counter_bank_rate_estimator] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/crbe_pkg.sv
sv/crbe_div.sv
sv/crbe_rate_upd.sv
sv/counter_bank_rate_estimator.sv
sim/counter_bank_rate_estimator_tb.sv
